### rtl/rsem_pkg.sv
// Shared constants, types and arithmetic helpers for the Sobel edge magnitude unit.
package rsem_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int DRAIN_W     = COL_W + 1;
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;
    localparam int SQ_W        = 18;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [2:0] ADDR_WIDTH  = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;

    typedef enum logic [1:0] {F_IDLE, F_EXEC, F_PUSH2} front_state_t;
    typedef enum logic [1:0] {B_IDLE, B_ROOT, B_OUT} back_state_t;

    typedef struct packed {
        logic [7:0] ax;
        logic [7:0] ay;
        logic       row_end;
        logic       frame_end;
        logic       last;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [15:0] sum;
        sum = 16'(16'd54 * r) + 16'(16'd184 * g) + 16'(16'd18 * b) + 16'd128;
        return sum[15:8];
    endfunction

    function automatic logic [7:0] grad(input logic [7:0] p0, input logic [7:0] p1,
                                        input logic [7:0] p2, input logic [7:0] m0,
                                        input logic [7:0] m1, input logic [7:0] m2);
        logic signed [11:0] d;
        d = $signed({2'b00, p0, 1'b0} >> 1) + $signed({2'b00, p1, 1'b0})
          + $signed({4'b0, p2}) - $signed({4'b0, m0}) - $signed({3'b0, m1, 1'b0})
          - $signed({4'b0, m2});
        if (d < 0)
            return 8'd0;
        else if (d > 12'sd255)
            return 8'd255;
        else
            return d[7:0];
    endfunction

endpackage

### rtl/rgb_sobel_edge_magnitude_unit.sv
// Top level of the RGB Sobel edge magnitude unit with its register port.
// An item is taken only while the front part is idle and the queue has room for two
// jobs, so a new item waits until the jobs of the last one are pushed; one item can
// cause two results, the second following the first. The back part's 9-step square
// root loop handles one job at a time and limits the rate of delivery.
// Reset (rst_n, asynchronous, active low) clears counters, window, queue and
// the output stage; line buffer contents are undefined until written.
module rgb_sobel_edge_magnitude_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // magnitude
    output logic [1:0]  m_tuser,   // row_end [0], frame_end [1]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rsem_pkg::*;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                wr;
    push_t               push;
    job_t                head;
    logic                not_empty, pop;
    logic [QCNT_W-1:0]   q_count;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr)
        begin
            if (paddr == ADDR_WIDTH)
                width_reg <= pwdata[WIDTH_W-1:0];
            else if (paddr == ADDR_HEIGHT)
                height_reg <= pwdata[HEIGHT_W-1:0];
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_WIDTH:  prdata = 32'(width_reg);
            ADDR_HEIGHT: prdata = 32'(height_reg);
            default:     prdata = '0;
        endcase
    end

    rsem_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_mode    (s_tuser),
        .in_red     (s_tdata[7:0]),
        .in_green   (s_tdata[15:8]),
        .in_blue    (s_tdata[23:16]),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .q_count    (q_count),
        .push       (push)
    );

    rsem_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    rsem_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .not_empty     (not_empty),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_magnitude (m_tdata),
        .out_row_end   (m_tuser[0]),
        .out_frame_end (m_tuser[1]),
        .out_last      (m_tlast)
    );

endmodule

### rtl/rsem_queue.sv
// Short job queue between the front and back parts.
module rsem_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  rsem_pkg::push_t push,
    input  logic          pop,
    output rsem_pkg::job_t head,
    output logic          not_empty,
    output logic [rsem_pkg::QCNT_W-1:0] count
);
    import rsem_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_pop;

    assign do_pop    = pop && (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign not_empty = (cnt_reg != '0);
    assign count     = cnt_reg;

    always_comb
    begin
        wr_next  = push.valid ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push.valid) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_reg] <= push.job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid && !do_pop |-> cnt_reg < QCNT_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/rsem_front.sv
// Front part: accepts items, keeps line buffers and window, builds gradient jobs.
module rsem_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_mode,
    input  logic [7:0]                    in_red,
    input  logic [7:0]                    in_green,
    input  logic [7:0]                    in_blue,
    input  logic [rsem_pkg::WIDTH_W-1:0]  cfg_width,
    input  logic [rsem_pkg::HEIGHT_W-1:0] cfg_height,
    input  logic [rsem_pkg::QCNT_W-1:0]   q_count,
    output rsem_pkg::push_t               push
);
    import rsem_pkg::*;

    front_state_t         state_reg, state_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [HEIGHT_W-1:0]  row_reg, row_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;
    logic [7:0]           win_reg [6];
    logic [7:0]           win_next [6];
    logic [COL_W-1:0]     x_reg, x_next;
    logic                 flush_reg, flush_next;
    logic [7:0]           gray_reg, gray_next;
    job_t                 hold_reg, hold_next;

    logic [7:0]           above_mem [MAX_WIDTH];
    logic [7:0]           middle_mem [MAX_WIDTH];
    logic [7:0]           above_rd, middle_rd;
    logic                 rd_en, wr_en;

    logic [WIDTH_W-1:0]   w_eff;
    logic [HEIGHT_W-1:0]  h_eff;
    logic [WIDTH_W-1:0]   w_last;
    logic                 accept, room;
    logic [7:0]           n0, n1, n2;
    logic                 emit, fa, fb;
    job_t                 job_a, job_b;
    logic [7:0]           bl0, bl1, bl2;

    always_comb
    begin
        if (cfg_width == '0)
            w_eff = WIDTH_W'(1);
        else if (cfg_width > WIDTH_W'(MAX_WIDTH))
            w_eff = WIDTH_W'(MAX_WIDTH);
        else
            w_eff = cfg_width;
        h_eff  = (cfg_height == '0) ? HEIGHT_W'(1) : cfg_height;
        w_last = w_eff - 1'b1;
    end

    assign room     = q_count <= QCNT_W'(QUEUE_DEPTH - 2);
    assign in_ready = (state_reg == F_IDLE) && room;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        n0 = (row_reg >= HEIGHT_W'(2)) ? above_rd : 8'd0;
        n1 = (flush_reg || row_reg >= HEIGHT_W'(1)) ? middle_rd : 8'd0;
        n2 = flush_reg ? 8'd0 : gray_reg;
        emit = flush_reg || (row_reg >= HEIGHT_W'(1));
        fa = emit && (x_reg != '0);
        fb = emit && ({1'b0, x_reg} == w_last);
        bl0 = (x_reg == '0) ? 8'd0 : win_reg[3];
        bl1 = (x_reg == '0) ? 8'd0 : win_reg[4];
        bl2 = (x_reg == '0) ? 8'd0 : win_reg[5];
        job_a.ax        = grad(n0, n1, n2, win_reg[0], win_reg[1], win_reg[2]);
        job_a.ay        = grad(win_reg[2], win_reg[5], n2, win_reg[0], win_reg[3], n0);
        job_a.row_end   = 1'b0;
        job_a.frame_end = 1'b0;
        job_a.last      = !fb;
        job_b.ax        = grad(8'd0, 8'd0, 8'd0, bl0, bl1, bl2);
        job_b.ay        = grad(bl2, n2, 8'd0, bl0, n0, 8'd0);
        job_b.row_end   = 1'b1;
        job_b.frame_end = flush_reg;
        job_b.last      = 1'b1;
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        win_next   = win_reg;
        x_next     = x_reg;
        flush_next = flush_reg;
        gray_next  = gray_reg;
        hold_next  = hold_reg;
        push       = '0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    flush_next = in_mode;
                    gray_next  = gray_of(in_red, in_green, in_blue);
                    if (in_mode)
                    begin
                        if (row_reg >= h_eff && {1'b0, drain_reg} < {1'b0, w_eff})
                        begin
                            x_next     = drain_reg[COL_W-1:0];
                            rd_en      = 1'b1;
                            state_next = F_EXEC;
                        end
                    end
                    else
                    begin
                        if (row_reg >= h_eff)
                        begin
                            row_next   = '0;
                            drain_next = '0;
                            x_next     = '0;
                        end
                        else if ({1'b0, col_reg} >= w_eff)
                            x_next = w_last[COL_W-1:0];
                        else
                            x_next = col_reg;
                        rd_en      = 1'b1;
                        state_next = F_EXEC;
                    end
                end
            end
            F_EXEC:
            begin
                if (fa)
                    push = '{valid: 1'b1, job: job_a};
                else if (fb)
                    push = '{valid: 1'b1, job: job_b};
                hold_next  = job_b;
                state_next = (fa && fb) ? F_PUSH2 : F_IDLE;
                if (x_reg == '0)
                begin
                    win_next[0] = 8'd0;
                    win_next[1] = 8'd0;
                    win_next[2] = 8'd0;
                end
                else
                begin
                    win_next[0] = win_reg[3];
                    win_next[1] = win_reg[4];
                    win_next[2] = win_reg[5];
                end
                win_next[3] = n0;
                win_next[4] = n1;
                win_next[5] = n2;
                if (flush_reg)
                    drain_next = {1'b0, x_reg} + 1'b1;
                else
                begin
                    wr_en = 1'b1;
                    if ({1'b0, x_reg} >= w_last)
                    begin
                        col_next   = '0;
                        row_next   = row_reg + 1'b1;
                        drain_next = '0;
                    end
                    else
                        col_next = x_reg + 1'b1;
                end
            end
            F_PUSH2:
            begin
                push       = '{valid: 1'b1, job: hold_reg};
                state_next = F_IDLE;
            end
            default:
                state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
            win_reg   <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        flush_reg <= flush_next;
        gray_reg  <= gray_next;
        hold_reg  <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            above_rd  <= above_mem[x_next];
            middle_rd <= middle_mem[x_next];
        end
        if (wr_en)
        begin
            above_mem[x_reg]  <= n1;
            middle_mem[x_reg] <= n2;
        end
    end

    a_push_state: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> state_reg == F_EXEC || state_reg == F_PUSH2)
        else $error("push outside execute");

    a_second_push: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == F_PUSH2 |-> $past(state_reg) == F_EXEC && push.job.last)
        else $error("second job out of sequence");

endmodule

### rtl/rsem_back.sv
// Back part: squares the gradients, takes an iterative square root, holds the result.
module rsem_back (
    input  logic           clk,
    input  logic           rst_n,
    input  rsem_pkg::job_t head,
    input  logic           not_empty,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     out_magnitude,
    output logic           out_row_end,
    output logic           out_frame_end,
    output logic           out_last
);
    import rsem_pkg::*;

    back_state_t       state_reg, state_next;
    logic [SQ_W-1:0]   v_reg, v_next, r_reg, r_next, bit_reg, bit_next;
    logic [2:0]        flags_reg, flags_next;
    logic              valid_reg, valid_next;
    logic [7:0]        mag_reg, mag_next;
    logic [2:0]        oflags_reg, oflags_next;
    logic [15:0]       sq_x, sq_y;
    logic [SQ_W-1:0]   trial;

    assign sq_x  = 16'(head.ax * head.ax);
    assign sq_y  = 16'(head.ay * head.ay);
    assign trial = r_reg + bit_reg;

    always_comb
    begin
        state_next  = state_reg;
        v_next      = v_reg;
        r_next      = r_reg;
        bit_next    = bit_reg;
        flags_next  = flags_reg;
        valid_next  = valid_reg && !out_ready;
        mag_next    = mag_reg;
        oflags_next = oflags_reg;
        pop         = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (not_empty)
                begin
                    pop        = 1'b1;
                    v_next     = SQ_W'(sq_x) + SQ_W'(sq_y);
                    r_next     = '0;
                    bit_next   = SQ_W'(1) << 16;
                    flags_next = {head.row_end, head.frame_end, head.last};
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                if (v_reg >= trial)
                begin
                    v_next = v_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                    r_next = r_reg >> 1;
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!valid_reg || out_ready)
                begin
                    valid_next  = 1'b1;
                    mag_next    = (r_reg > SQ_W'(255)) ? 8'd255 : r_reg[7:0];
                    oflags_next = flags_reg;
                    state_next  = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        r_reg      <= r_next;
        bit_reg    <= bit_next;
        flags_reg  <= flags_next;
        mag_reg    <= mag_next;
        oflags_reg <= oflags_next;
    end

    assign out_valid     = valid_reg;
    assign out_magnitude = mag_reg;
    assign out_row_end   = oflags_reg[2];
    assign out_frame_end = oflags_reg[1];
    assign out_last      = oflags_reg[0];

endmodule
